### rtl/rie_pkg.sv
`timescale 1ns / 1ps

package rie_pkg;

  // Register file geometry and fixed register roles.
  localparam int REG_W    = 3;
  localparam int NUM_REGS = 8;

  localparam logic [REG_W-1:0] REG_ZERO = 3'd0;
  localparam logic [REG_W-1:0] REG_IMM  = 3'd1;
  localparam logic [REG_W-1:0] REG_LINK = 3'd7;

  // Instruction opcodes.
  typedef enum logic [4:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_SLL  = 5'd2,
    OP_SRA  = 5'd3,
    OP_AND  = 5'd4,
    OP_OR   = 5'd5,
    OP_XOR  = 5'd6,
    OP_LHI  = 5'd7,
    OP_LD   = 5'd8,
    OP_ST   = 5'd9,
    OP_JLT  = 5'd16,
    OP_JLE  = 5'd17,
    OP_JEQ  = 5'd18,
    OP_JNE  = 5'd19,
    OP_JIN  = 5'd20,
    OP_HALT = 5'd24
  } rie_op_t;

  // Control flags produced by the execute logic for one instruction.
  typedef struct packed {
    logic wr;
    logic load;
    logic store;
    logic halt;
  } rie_ctl_t;

endpackage

### rtl/rie_alu.sv
`timescale 1ns / 1ps

module rie_alu import rie_pkg::*; #(
  parameter int DATA_BITS = 32,
  parameter int PC_BITS   = 16,
  parameter int LHI_SHIFT = 16
) (
  input  logic [4:0]           mode,
  input  logic [REG_W-1:0]     dest_reg,
  input  logic [REG_W-1:0]     src_a_reg,
  input  logic [DATA_BITS-1:0] op_a,
  input  logic [DATA_BITS-1:0] op_b,
  input  logic [DATA_BITS-1:0] imm_ext,
  input  logic [15:0]          cur_pc,
  output logic [DATA_BITS-1:0] result,
  output logic [PC_BITS-1:0]   next_pc,
  output logic [REG_W-1:0]     wreg,
  output rie_ctl_t             ctl
);

  localparam int SHW = $clog2(DATA_BITS);
  localparam logic [DATA_BITS-1:0] LHI_MASK = ~({DATA_BITS{1'b1}} << LHI_SHIFT);

  logic [SHW-1:0]     shamt;
  logic               shift_big;
  logic               lt_ab;
  logic               lt_ba;
  logic               rd_nop;
  logic               take;
  logic [PC_BITS-1:0] pc_inc;
  logic [DATA_BITS-1:0] link_val;

  // Shared operand conditions.
  assign shamt     = op_b[SHW-1:0];
  assign shift_big = (op_b >= DATA_BITS'(DATA_BITS));
  assign lt_ab     = ($signed(op_a) < $signed(op_b));
  assign lt_ba     = ($signed(op_b) < $signed(op_a));
  assign rd_nop    = (mode <= OP_LD) && (dest_reg == REG_ZERO);
  assign pc_inc    = PC_BITS'(cur_pc) + PC_BITS'(1);
  assign link_val  = DATA_BITS'(cur_pc);

  // Opcode decode and result selection.
  always_comb begin
    result  = '0;
    next_pc = pc_inc;
    wreg    = dest_reg;
    ctl     = '0;
    take    = 1'b0;
    if (!rd_nop) begin
      unique case (rie_op_t'(mode))
        OP_ADD: begin
          result = op_a + op_b;
          ctl.wr = 1'b1;
        end
        OP_SUB: begin
          result = op_a - op_b;
          ctl.wr = 1'b1;
        end
        OP_SLL: begin
          result = shift_big ? '0 : (op_a << shamt);
          ctl.wr = 1'b1;
        end
        OP_SRA: begin
          result = shift_big ? {DATA_BITS{op_a[DATA_BITS-1]}}
                             : DATA_BITS'($signed(op_a) >>> shamt);
          ctl.wr = 1'b1;
        end
        OP_AND: begin
          result = op_a & op_b;
          ctl.wr = 1'b1;
        end
        OP_OR: begin
          result = op_a | op_b;
          ctl.wr = 1'b1;
        end
        OP_XOR: begin
          result = op_a ^ op_b;
          ctl.wr = 1'b1;
        end
        OP_LHI: begin
          // The second operand holds the destination register here.
          result = (op_b & LHI_MASK) | (imm_ext << LHI_SHIFT);
          ctl.wr = 1'b1;
        end
        OP_LD: begin
          ctl.wr   = 1'b1;
          ctl.load = 1'b1;
        end
        OP_ST: begin
          ctl.store = 1'b1;
        end
        OP_JLT, OP_JLE, OP_JEQ, OP_JNE: begin
          priority case (rie_op_t'(mode))
            OP_JLT:  take = lt_ab;
            OP_JLE:  take = !lt_ba;
            OP_JEQ:  take = (op_a == op_b);
            default: take = (op_a != op_b);
          endcase
          if (take) begin
            wreg    = REG_LINK;
            result  = link_val;
            ctl.wr  = 1'b1;
            next_pc = PC_BITS'(imm_ext);
          end
        end
        OP_JIN: begin
          // The link write happens first, so a jump through the link
          // register lands on this instruction.
          wreg    = REG_LINK;
          result  = link_val;
          ctl.wr  = 1'b1;
          next_pc = (src_a_reg == REG_LINK) ? PC_BITS'(cur_pc) : PC_BITS'(op_a);
        end
        OP_HALT: begin
          ctl.halt = 1'b1;
          next_pc  = '1;
        end
        default: begin
          result = '0;
        end
      endcase
    end
  end

endmodule

### rtl/risc_instruction_execute.sv
`timescale 1ns / 1ps
// An accepted instruction is registered into the execute stage, then into the write-back
// stage, then into the output register. An instruction enters only when execute is empty
// and write back is empty or retiring, so one instruction is in execute at a time. When
// MEM_WORDS is not a power of two, loads and stores wait in execute for the address
// reduction. Reset clears the pipeline and the register file valid bits; the data memory
// holds no defined contents until written.

module risc_instruction_execute import rie_pkg::*; #(
  parameter int MEM_WORDS = 4096,
  parameter int DATA_BITS = 32,
  parameter int PC_BITS   = 16,
  parameter int LHI_SHIFT = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         mode,
  input  logic [2:0]         dest_reg,
  input  logic [2:0]         src_a_reg,
  input  logic [2:0]         src_b_reg,
  input  logic signed [15:0] immediate,
  input  logic [15:0]        cur_pc,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        next_pc,
  output logic               halted,
  output logic               write_enable,
  output logic signed [31:0] write_value
);

  localparam int AW   = $clog2(MEM_WORDS);
  localparam bit POW2 = (MEM_WORDS == (1 << AW));

  // Handshake and pipeline control.
  logic in_accept;
  logic ex_valid;
  logic ex_adv;
  logic ex_mem;
  logic addr_ok;
  logic wb_valid;
  logic wb_retire;

  // Register file memory with two registered read ports.
  logic [DATA_BITS-1:0] rf [NUM_REGS];
  logic [NUM_REGS-1:0]  rf_vld;
  logic                 rf_we;
  logic [REG_W-1:0]     rf_waddr;
  logic [DATA_BITS-1:0] rf_wdata;
  logic [REG_W-1:0]     rd_addr_b;
  logic [DATA_BITS-1:0] rd_data_a;
  logic [DATA_BITS-1:0] rd_data_b;

  // Execute stage.
  logic [4:0]           ex_mode;
  logic [REG_W-1:0]     ex_dest;
  logic [REG_W-1:0]     ex_src_a;
  logic [REG_W-1:0]     ex_addr_b;
  logic signed [15:0]   ex_imm;
  logic [15:0]          ex_pc;
  logic [DATA_BITS-1:0] imm_ext;
  logic [DATA_BITS-1:0] op_a;
  logic [DATA_BITS-1:0] op_b;
  logic [DATA_BITS-1:0] alu_res;
  logic [PC_BITS-1:0]   alu_next;
  logic [REG_W-1:0]     alu_wreg;
  rie_ctl_t             alu_ctl;

  // Data memory.
  logic [DATA_BITS-1:0] dmem [MEM_WORDS];
  logic [DATA_BITS-1:0] dmem_q;
  logic [AW-1:0]        mem_addr;

  // Write-back stage.
  logic [DATA_BITS-1:0] wb_res;
  logic [PC_BITS-1:0]   wb_next;
  logic                 wb_halt;
  logic                 wb_wr;
  logic                 wb_load;
  logic [REG_W-1:0]     wb_wreg;
  logic [DATA_BITS-1:0] wb_value;

  // An instruction enters only when execute is empty and write back is empty or drains now.
  assign wb_retire = wb_valid && (!out_valid || !out_stall);
  assign ex_adv    = ex_valid && addr_ok && (!wb_valid || wb_retire);
  assign in_stall  = rst || ex_valid || (wb_valid && !wb_retire);
  assign in_accept = in_valid && !in_stall;

  // Load-high reads its destination through the second port.
  assign rd_addr_b = (mode == OP_LHI) ? dest_reg : src_b_reg;

  assign rf_we    = wb_retire && wb_wr;
  assign rf_waddr = wb_wreg;
  assign rf_wdata = wb_value;

  // Register file write and read, forwarding a write of the same edge.
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf[rf_waddr] <= rf_wdata;
    end
    if (in_accept) begin
      if (rf_we && (rf_waddr == src_a_reg)) begin
        rd_data_a <= rf_wdata;
      end else begin
        rd_data_a <= rf_vld[src_a_reg] ? rf[src_a_reg] : '0;
      end
      if (rf_we && (rf_waddr == rd_addr_b)) begin
        rd_data_b <= rf_wdata;
      end else begin
        rd_data_b <= rf_vld[rd_addr_b] ? rf[rd_addr_b] : '0;
      end
    end
  end

  // Entries read as zero until first written.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_vld <= '0;
    end else if (rf_we) begin
      rf_vld[rf_waddr] <= 1'b1;
    end
  end

  // Execute stage occupancy and instruction fields.
  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (in_accept) begin
      ex_valid <= 1'b1;
    end else if (ex_adv) begin
      ex_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ex_mode   <= mode;
      ex_dest   <= dest_reg;
      ex_src_a  <= src_a_reg;
      ex_addr_b <= rd_addr_b;
      ex_imm    <= immediate;
      ex_pc     <= cur_pc;
    end
  end

  // Register 1 always holds this instruction's immediate.
  assign imm_ext = DATA_BITS'(ex_imm);
  assign op_a    = (ex_src_a == REG_IMM) ? imm_ext : rd_data_a;
  assign op_b    = (ex_addr_b == REG_IMM) ? imm_ext : rd_data_b;

  rie_alu #(
    .DATA_BITS (DATA_BITS),
    .PC_BITS   (PC_BITS),
    .LHI_SHIFT (LHI_SHIFT)
  ) u_alu (
    .mode      (ex_mode),
    .dest_reg  (ex_dest),
    .src_a_reg (ex_src_a),
    .op_a      (op_a),
    .op_b      (op_b),
    .imm_ext   (imm_ext),
    .cur_pc    (ex_pc),
    .result    (alu_res),
    .next_pc   (alu_next),
    .wreg      (alu_wreg),
    .ctl       (alu_ctl)
  );

  assign ex_mem = ex_valid && (alu_ctl.load || alu_ctl.store);

  // Memory address: the register value reduced modulo the memory depth.
  if (POW2) begin : g_addr_mask
    assign mem_addr = op_b[AW-1:0];
    assign addr_ok  = 1'b1;
  end else begin : g_addr_mod
    localparam int ND = (DATA_BITS + 15) / 16;
    localparam int XW = ND * 16;
    localparam int VW = AW + 16;
    localparam int SH = 2 * AW + 16;
    localparam int MW = AW + 17;
    localparam int PW = VW + MW;
    localparam int CW = $clog2(2 * ND + 1);
    localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SH) + 64'(MEM_WORDS) - 64'd1) / 64'(MEM_WORDS);
    localparam logic [MW-1:0] RECIP = RECIP_FULL[MW-1:0];

    logic [CW-1:0] mod_cnt;
    logic [AW-1:0] mod_rem;
    logic [XW-1:0] mod_sh;
    logic [VW-1:0] mod_val;
    logic [15:0]   mod_q;
    logic [AW-1:0] rem_cur;
    logic [XW-1:0] sh_cur;
    logic [VW-1:0] val_cur;
    logic [PW-1:0] prod;
    logic [VW-1:0] rem_diff;
    logic          mod_busy;

    // Sixteen address bits per digit, most significant digit first. The even step finds
    // the digit quotient by reciprocal multiplication, the odd step subtracts quotient
    // times depth to leave the running remainder.
    assign mod_busy = ex_mem && (mod_cnt != CW'(2 * ND));
    assign rem_cur  = (mod_cnt == '0) ? '0 : mod_rem;
    assign sh_cur   = (mod_cnt == '0) ? XW'(op_b) : mod_sh;
    assign val_cur  = {rem_cur, sh_cur[XW-1 -: 16]};
    assign prod     = PW'(val_cur) * PW'(RECIP);
    assign rem_diff = mod_val - VW'(mod_q) * VW'(MEM_WORDS);

    always_ff @(posedge clk) begin
      if (rst) begin
        mod_cnt <= '0;
      end else if (ex_adv) begin
        mod_cnt <= '0;
      end else if (mod_busy) begin
        mod_cnt <= mod_cnt + CW'(1);
      end
    end

    always_ff @(posedge clk) begin
      if (mod_busy && !mod_cnt[0]) begin
        mod_val <= val_cur;
        mod_q   <= prod[SH +: 16];
        mod_sh  <= sh_cur << 16;
      end
      if (mod_busy && mod_cnt[0]) begin
        mod_rem <= rem_diff[AW-1:0];
      end
    end

    assign mem_addr = mod_rem;
    assign addr_ok  = !ex_mem || (mod_cnt == CW'(2 * ND));
  end

  // Data memory: store writes and load reads issue as execute hands over.
  always_ff @(posedge clk) begin
    if (ex_adv && alu_ctl.store) begin
      dmem[mem_addr] <= op_a;
    end
    if (ex_adv && alu_ctl.load) begin
      dmem_q <= dmem[mem_addr];
    end
  end

  // Write-back stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else if (ex_adv) begin
      wb_valid <= 1'b1;
    end else if (wb_retire) begin
      wb_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_adv) begin
      wb_res  <= alu_res;
      wb_next <= alu_next;
      wb_halt <= alu_ctl.halt;
      wb_wr   <= alu_ctl.wr;
      wb_load <= alu_ctl.load;
      wb_wreg <= alu_wreg;
    end
  end

  assign wb_value = wb_load ? dmem_q : wb_res;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb_retire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb_retire) begin
      next_pc      <= 16'(wb_next);
      halted       <= wb_halt;
      write_enable <= wb_wr;
      write_value  <= wb_wr ? 32'(wb_value) : '0;
    end
  end

endmodule

### rtl/rie_checker.sv
`timescale 1ns / 1ps

module rie_checker #(
  parameter int PC_BITS = 16
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [15:0]        next_pc,
  input logic               halted,
  input logic               write_enable,
  input logic signed [31:0] write_value
);

  localparam logic [15:0] HALT_PC = 16'({PC_BITS{1'b1}});

  // An accepted instruction stalls the input in the next cycle.
  a_issue_gap: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(next_pc) && $stable(halted)
      && $stable(write_enable) && $stable(write_value)))
    else $error("stalled result changed");

  // A halt writes no register and points at the all-ones address.
  a_halt: assert property (@(posedge clk) disable iff (rst)
    (out_valid && halted) |-> (!write_enable && (next_pc == HALT_PC)))
    else $error("halt result malformed");

  // Without a register write the reported value is zero.
  a_wval: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !write_enable) |-> (write_value == 32'sd0))
    else $error("write value nonzero without write");

  // Reset empties the output.
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind risc_instruction_execute rie_checker #(.PC_BITS(PC_BITS)) u_rie_checker (.*);

### bench/tb_risc_instruction_execute.sv
`timescale 1ns / 1ps

module tb_risc_instruction_execute;
  import rie_pkg::*;

  // Opcodes outside the instruction set; the block treats them as no-ops.
  localparam logic [4:0] OP_NONE_LO = 5'd10;
  localparam logic [4:0] OP_NONE_HI = 5'd31;

  localparam int RAND_PER_PHASE = 467;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [4:0]  op;
    logic [2:0]  rd;
    logic [2:0]  ra;
    logic [2:0]  rb;
    logic [15:0] imm;
    logic [15:0] pc;
  } instr_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        halted;
    logic        we;
    logic [31:0] value;
  } result_t;

  typedef struct packed {
    instr_t  ins;
    logic    typed;
    result_t res;
  } dir_row_t;

  localparam int DIR_ROWS = 25;

  // Directed instructions. Rows with typed set carry a result that depends only on
  // register 0 and the immediate; the other rows are checked against the predictor.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{'{OP_ADD,  3'd2, 3'd0, 3'd0, 16'h0000, 16'h0000}, 1'b1, '{16'h0001, 1'b0, 1'b1, 32'h0}},
    '{'{OP_ADD,  3'd2, 3'd1, 3'd1, 16'h7FFF, 16'h0010}, 1'b1,
      '{16'h0011, 1'b0, 1'b1, 32'h0000FFFE}},
    '{'{OP_SUB,  3'd3, 3'd0, 3'd1, 16'h8000, 16'hFFFF}, 1'b1,
      '{16'h0000, 1'b0, 1'b1, 32'h00008000}},
    '{'{OP_SLL,  3'd4, 3'd1, 3'd1, 16'h0028, 16'h0100}, 1'b1, '{16'h0101, 1'b0, 1'b1, 32'h0}},
    '{'{OP_SRA,  3'd5, 3'd1, 3'd1, 16'hFFFF, 16'h0103}, 1'b1,
      '{16'h0104, 1'b0, 1'b1, 32'hFFFFFFFF}},
    '{'{OP_SRA,  3'd5, 3'd1, 3'd0, 16'h8000, 16'h0104}, 1'b1,
      '{16'h0105, 1'b0, 1'b1, 32'hFFFF8000}},
    '{'{OP_AND,  3'd6, 3'd1, 3'd1, 16'hAAAA, 16'h0105}, 1'b1,
      '{16'h0106, 1'b0, 1'b1, 32'hFFFFAAAA}},
    '{'{OP_XOR,  3'd6, 3'd1, 3'd1, 16'hFFFF, 16'h0106}, 1'b1, '{16'h0107, 1'b0, 1'b1, 32'h0}},
    '{'{OP_LHI,  3'd1, 3'd0, 3'd0, 16'h1234, 16'h0107}, 1'b1,
      '{16'h0108, 1'b0, 1'b1, 32'h12341234}},
    '{'{OP_LHI,  3'd2, 3'd0, 3'd0, 16'hFFFF, 16'h0108}, 1'b0, '0},
    '{'{OP_ST,   3'd0, 3'd1, 3'd0, 16'h0777, 16'h0200}, 1'b1, '{16'h0201, 1'b0, 1'b0, 32'h0}},
    '{'{OP_LD,   3'd3, 3'd0, 3'd0, 16'h0000, 16'h0201}, 1'b0, '0},
    '{'{OP_ST,   3'd0, 3'd1, 3'd1, 16'hFFFF, 16'h0202}, 1'b1, '{16'h0203, 1'b0, 1'b0, 32'h0}},
    '{'{OP_LD,   3'd4, 3'd0, 3'd1, 16'hFFFF, 16'h0203}, 1'b0, '0},
    '{'{OP_ADD,  3'd0, 3'd1, 3'd1, 16'h1111, 16'h0300}, 1'b1, '{16'h0301, 1'b0, 1'b0, 32'h0}},
    '{'{OP_JLT,  3'd0, 3'd0, 3'd1, 16'h0005, 16'h0064}, 1'b1,
      '{16'h0005, 1'b0, 1'b1, 32'h00000064}},
    '{'{OP_JLT,  3'd0, 3'd1, 3'd0, 16'hFFFD, 16'h0070}, 1'b1,
      '{16'hFFFD, 1'b0, 1'b1, 32'h00000070}},
    '{'{OP_JLE,  3'd0, 3'd1, 3'd1, 16'h0020, 16'h0030}, 1'b1,
      '{16'h0020, 1'b0, 1'b1, 32'h00000030}},
    '{'{OP_JEQ,  3'd0, 3'd0, 3'd1, 16'h0000, 16'h0040}, 1'b1,
      '{16'h0000, 1'b0, 1'b1, 32'h00000040}},
    '{'{OP_JNE,  3'd0, 3'd0, 3'd1, 16'h0000, 16'h0041}, 1'b1, '{16'h0042, 1'b0, 1'b0, 32'h0}},
    '{'{OP_JIN,  3'd3, 3'd7, 3'd0, 16'h0000, 16'h4321}, 1'b1,
      '{16'h4321, 1'b0, 1'b1, 32'h00004321}},
    '{'{OP_JIN,  3'd0, 3'd1, 3'd0, 16'hFFFE, 16'h0000}, 1'b1, '{16'hFFFE, 1'b0, 1'b1, 32'h0}},
    '{'{OP_HALT, 3'd0, 3'd0, 3'd0, 16'h0000, 16'h0055}, 1'b1, '{16'hFFFF, 1'b1, 1'b0, 32'h0}},
    '{'{OP_NONE_HI, 3'd0, 3'd0, 3'd0, 16'h0000, 16'hFFFF}, 1'b1,
      '{16'h0000, 1'b0, 1'b0, 32'h0}},
    '{'{OP_NONE_LO, 3'd5, 3'd2, 3'd3, 16'h0000, 16'h1234}, 1'b1,
      '{16'h1235, 1'b0, 1'b0, 32'h0}}
  };

  rie_op_t op_pool [16] = '{OP_ADD, OP_SUB, OP_SLL, OP_SRA, OP_AND, OP_OR, OP_XOR, OP_LHI,
                            OP_LD, OP_ST, OP_JLT, OP_JLE, OP_JEQ, OP_JNE, OP_JIN, OP_HALT};

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [4:0]         mode         = '0;
  logic [2:0]         dest_reg     = '0;
  logic [2:0]         src_a_reg    = '0;
  logic [2:0]         src_b_reg    = '0;
  logic signed [15:0] immediate    = '0;
  logic [15:0]        cur_pc       = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [15:0]        next_pc;
  logic               halted;
  logic               write_enable;
  logic signed [31:0] write_value;

  // Shadow of the architectural state and the results still in flight.
  logic [31:0]  arch_regs [8];
  logic [31:0]  mem_img [int unsigned];
  logic [11:0]  stored_addrs [$];
  result_t      exp_q [$];
  result_t      want_res;

  int unsigned send_pct   = 0;
  int unsigned recv_pct   = 0;
  int          n_errors   = 0;
  int          cycle_cnt  = 0;

  risc_instruction_execute i_dut (.*);

  always #2 clk = ~clk;

  // Executes one instruction on the shadow state and returns its result.
  function automatic result_t execute_instr(input instr_t it);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] res;
    logic [15:0] nxt;
    logic        wr;
    logic        hlt;
    logic        take;
    logic [2:0]  wreg;
    result_t     r;
    nxt  = it.pc + 16'd1;
    res  = '0;
    wr   = 1'b0;
    hlt  = 1'b0;
    take = 1'b0;
    wreg = it.rd;
    arch_regs[REG_IMM] = {{16{it.imm[15]}}, it.imm};
    a = arch_regs[it.ra];
    b = arch_regs[it.rb];
    if (!(it.op <= OP_LD && it.rd == REG_ZERO)) begin
      case (it.op)
        OP_ADD: begin res = a + b; wr = 1'b1; end
        OP_SUB: begin res = a - b; wr = 1'b1; end
        OP_SLL: begin res = (b >= 32) ? 32'h0 : a << b[4:0]; wr = 1'b1; end
        OP_SRA: begin
          if (b >= 32) res = {32{a[31]}};
          else res = $signed(a) >>> b[4:0];
          wr = 1'b1;
        end
        OP_AND: begin res = a & b; wr = 1'b1; end
        OP_OR:  begin res = a | b; wr = 1'b1; end
        OP_XOR: begin res = a ^ b; wr = 1'b1; end
        OP_LHI: begin res = {arch_regs[REG_IMM][15:0], arch_regs[it.rd][15:0]}; wr = 1'b1; end
        OP_LD:  begin res = mem_img[b[11:0]]; wr = 1'b1; end
        OP_ST: begin
          if (!mem_img.exists(b[11:0])) stored_addrs.push_back(b[11:0]);
          mem_img[b[11:0]] = a;
        end
        OP_JLT, OP_JLE, OP_JEQ, OP_JNE: begin
          case (it.op)
            OP_JLT:  take = $signed(a) < $signed(b);
            OP_JLE:  take = !($signed(b) < $signed(a));
            OP_JEQ:  take = (a == b);
            default: take = (a != b);
          endcase
          if (take) begin
            wreg = REG_LINK;
            res  = {16'h0, it.pc};
            wr   = 1'b1;
            arch_regs[REG_LINK] = res;
            nxt  = arch_regs[REG_IMM][15:0];
          end
        end
        // The link register is written first, so a jump through it lands on pc.
        OP_JIN: begin
          wreg = REG_LINK;
          res  = {16'h0, it.pc};
          wr   = 1'b1;
          arch_regs[REG_LINK] = res;
          nxt  = arch_regs[it.ra][15:0];
        end
        OP_HALT: begin
          hlt = 1'b1;
          nxt = 16'hFFFF;
        end
        default: ;
      endcase
    end
    if (wr) arch_regs[wreg] = res;
    r.next_pc = nxt;
    r.halted  = hlt;
    r.we      = wr;
    r.value   = wr ? res : 32'h0;
    return r;
  endfunction

  // Steers a load onto a stored word, or else into a store, so no undefined word is read.
  function automatic instr_t aim_load(input instr_t it);
    logic [31:0] addr;
    instr_t      o;
    o = it;
    if (it.op != OP_LD) return o;
    addr = (it.rb == REG_IMM) ? {{16{it.imm[15]}}, it.imm} : arch_regs[it.rb];
    if (mem_img.exists(addr[11:0])) return o;
    if (stored_addrs.size() == 0) begin
      o.op = OP_ST;
      return o;
    end
    o.rb  = REG_IMM;
    o.imm = {4'h0, stored_addrs[$urandom_range(stored_addrs.size() - 1)]};
    return o;
  endfunction

  // Mostly legal instructions with random content, plus some raw opcodes.
  function automatic instr_t rand_instr();
    instr_t it;
    it.rd  = 3'($urandom_range(7));
    it.ra  = 3'($urandom_range(7));
    it.rb  = 3'($urandom_range(7));
    it.imm = 16'($urandom);
    it.pc  = 16'($urandom);
    if ($urandom_range(99) < 8) it.op = 5'($urandom_range(31));
    else it.op = op_pool[$urandom_range(15)];
    // Small immediates give shift amounts around the data width and reused addresses.
    if ($urandom_range(3) == 0) it.imm = 16'($urandom_range(40));
    if (it.op >= OP_JLT && it.op <= OP_JNE && $urandom_range(2) == 0) it.rb = it.ra;
    if (it.op == OP_ST && $urandom_range(1) == 1) begin
      it.rb  = REG_IMM;
      it.imm = 16'($urandom_range(63));
    end
    return aim_load(it);
  endfunction

  // Offers one instruction, after an optional idle gap, and returns after its transfer.
  task automatic send_instr(input instr_t it);
    logic stalled;
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_pct);
    end
    in_valid  <= 1'b1;
    mode      <= it.op;
    dest_reg  <= it.rd;
    src_a_reg <= it.ra;
    src_b_reg <= it.rb;
    immediate <= it.imm;
    cur_pc    <= it.pc;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  // Holds the input idle until every outstanding result has been transferred.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_q.size() != 0);
  endtask

  // Result side back-pressure.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  // Checks each result transfer against the oldest outstanding expectation.
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (exp_q.size() == 0) begin
        $error("result transfer with no instruction outstanding");
        n_errors++;
      end else begin
        want_res = exp_q.pop_front();
        if (next_pc !== want_res.next_pc) begin
          $error("next_pc: expected %h, got %h", want_res.next_pc, next_pc);
          n_errors++;
        end
        if (halted !== want_res.halted) begin
          $error("halted: expected %b, got %b", want_res.halted, halted);
          n_errors++;
        end
        if (write_enable !== want_res.we) begin
          $error("write_enable: expected %b, got %b", want_res.we, write_enable);
          n_errors++;
        end
        if (write_value !== want_res.value) begin
          $error("write_value: expected %h, got %h", want_res.value, write_value);
          n_errors++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    instr_t  ins;
    result_t res;
    for (int r = 0; r < 8; r++) arch_regs[r] = '0;
    send_pct = 14;
    recv_pct = 62;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed instructions.
    for (int i = 0; i < DIR_ROWS; i++) begin
      ins = dir_tab[i].ins;
      res = execute_instr(ins);
      exp_q.push_back(dir_tab[i].typed ? dir_tab[i].res : res);
      send_instr(ins);
    end
    drain();

    // Random instructions under three idle patterns.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_pct = 14; recv_pct = 62; end
        1: begin send_pct = 62; recv_pct = 14; end
        default: begin send_pct = 0; recv_pct = 0; end
      endcase
      for (int n = 0; n < RAND_PER_PHASE; n++) begin
        ins = rand_instr();
        exp_q.push_back(execute_instr(ins));
        send_instr(ins);
      end
      drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
